// File: design/feedback_echo_delay_defines.svh
// ----------------------------------------------------------------------------
// feedback_echo_delay_defines.svh
// Assertion macros shared by the echo delay RTL. Empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_ECHO_DELAY_DEFINES_SVH
`define FEEDBACK_ECHO_DELAY_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is high.
`define FED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FED_ASSERT(lbl, clk, rst, prop, msg)
`define FED_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/fed_pkg.sv
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types and fixed constants of the feedback echo delay.
// ----------------------------------------------------------------------------
package fed_pkg;

   localparam int SAMPLE_WIDTH   = 24;
   localparam int MIX_WIDTH      = 17;
   localparam int FB_WIDTH       = 16;
   localparam int DELAY_WIDTH    = 17;
   localparam int CHCNT_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH = 17;
   localparam int CSR_IDX_WIDTH  = 2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // Q16 unity and the feedback ceiling (0.95)
   localparam logic [MIX_WIDTH-1:0]   Q16_ONE      = 17'd65536;
   localparam logic [FB_WIDTH-1:0]    FEEDBACK_MAX = 16'd62259;

   localparam logic [MIX_WIDTH-1:0]   MIX_RESET    = 17'd0;
   localparam logic [FB_WIDTH-1:0]    FB_RESET     = 16'd0;
   localparam logic [DELAY_WIDTH-1:0] DELAY_RESET  = 17'd24000;
   localparam logic [CHCNT_WIDTH-1:0] CHCNT_RESET  = 2'd2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MIX_LEVEL     = 2'd0,
      CSR_FEEDBACK_GAIN = 2'd1,
      CSR_DELAY_FRAMES  = 2'd2,
      CSR_CHANNEL_COUNT = 2'd3
   } csr_index_type;

   // gains handed to the arithmetic pipeline
   typedef struct packed {
      logic [MIX_WIDTH-1:0] mix_level;
      logic [FB_WIDTH-1:0]  feedback_gain;
   } coef_type;

endpackage

// File: design/fed_channels.sv
// ----------------------------------------------------------------------------
// fed_channels
// Valid/ready stream interfaces for samples in and mixed samples out.
// ----------------------------------------------------------------------------
interface fed_req_if import fed_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface fed_rsp_if import fed_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/fed_mix_math.sv
// ----------------------------------------------------------------------------
// fed_mix_math
// Product stage and round/saturate stage for the feedback and output mix.
// ----------------------------------------------------------------------------
module fed_mix_math import fed_pkg::*; (
   input  logic       clock,
   input  logic       load,
   input  sample_type dry,
   input  sample_type wet,
   input  coef_type   coef,
   input  logic       bypass,
   output sample_type store_sample,
   output sample_type mix_sample
);

   function automatic sample_type sat_sample(input logic signed [27:0] v);
      sample_type r;
      if (v > 28'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

   logic [MIX_WIDTH-1:0] mix_eff;
   logic [FB_WIDTH-1:0]  fb_eff;
   logic signed [16:0]   fb_s;
   logic signed [17:0]   mix_s;
   logic signed [17:0]   inv_s;

   sample_type         dry_ff, dry_in;
   logic signed [40:0] fb_prod_ff, fb_prod_in;
   logic signed [41:0] dry_prod_ff, dry_prod_in;
   logic signed [41:0] wet_prod_ff, wet_prod_in;

   logic signed [41:0] fb_acc;
   logic signed [25:0] fb_q;
   logic signed [27:0] st_sum;
   logic signed [43:0] mix_acc;

   always_comb begin
      mix_eff     = (coef.mix_level > Q16_ONE) ? Q16_ONE : coef.mix_level;
      fb_eff      = (coef.feedback_gain > FEEDBACK_MAX) ? FEEDBACK_MAX : coef.feedback_gain;
      fb_s        = $signed({1'b0, fb_eff});
      mix_s       = $signed({1'b0, mix_eff});
      inv_s       = $signed({1'b0, Q16_ONE - mix_eff});
      dry_in      = dry;
      fb_prod_in  = wet * fb_s;
      dry_prod_in = dry * inv_s;
      wet_prod_in = wet * mix_s;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dry_ff      <= dry_in;
         fb_prod_ff  <= fb_prod_in;
         dry_prod_ff <= dry_prod_in;
         wet_prod_ff <= wet_prod_in;
      end
   end

   // floor of (x + half) / 65536 is round to nearest, ties up
   always_comb begin
      fb_acc       = 42'(fb_prod_ff) + 42'sd32768;
      fb_q         = $signed(fb_acc[41:16]);
      st_sum       = 28'(fb_q) + 28'(dry_ff);
      store_sample = sat_sample(st_sum);
      mix_acc      = 44'(dry_prod_ff) + 44'(wet_prod_ff) + 44'sd32768;
      mix_sample   = bypass ? dry_ff : sat_sample($signed(mix_acc[43:16]));
   end

endmodule

// File: design/feedback_echo_delay.sv
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Feedback delay line echo on an interleaved audio stream.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the echo memory to zero, one entry per
// cycle, over its CAPACITY_FRAMES*MAX_CHANNELS entries (262144 at defaults);
// no sample transfer is taken during that sweep, csr writes are. After that one
// sample is taken per cycle while the result side and interlock allow it,
// and its result moves through the memory read, product and output registers.
// The echo memory has one read and one write port: it is read when a sample is
// taken and written two stages later; a sample whose delayed entry is still to
// be written by a sample in flight (short delays with few channels) waits until
// that write lands.
// With mix_level zero samples pass unchanged and state does not move.
// ----------------------------------------------------------------------------
`include "feedback_echo_delay_defines.svh"

module feedback_echo_delay import fed_pkg::*; #(
   parameter int CAPACITY_FRAMES = 131072,
   parameter int MAX_CHANNELS    = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   fed_req_if.sink                   req_chan,
   fed_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wr_data
);

   localparam int DEPTH = CAPACITY_FRAMES * MAX_CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $clog2(CAPACITY_FRAMES);
   localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NW    = CW + 1;                        // holds the channel count
   localparam int XW    = ((FW > DELAY_WIDTH) ? FW : DELAY_WIDTH) + 1;

   // ---------------- configuration registers ----------------
   logic [MIX_WIDTH-1:0]   mix_level_ff, mix_level_in;
   logic [FB_WIDTH-1:0]    feedback_gain_ff, feedback_gain_in;
   logic [DELAY_WIDTH-1:0] delay_frames_ff, delay_frames_in;
   logic [CHCNT_WIDTH-1:0] channel_count_ff, channel_count_in;

   always_comb begin
      mix_level_in     = mix_level_ff;
      feedback_gain_in = feedback_gain_ff;
      delay_frames_in  = delay_frames_ff;
      channel_count_in = channel_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIX_LEVEL:     mix_level_in     = csr_wr_data[MIX_WIDTH-1:0];
            CSR_FEEDBACK_GAIN: feedback_gain_in = csr_wr_data[FB_WIDTH-1:0];
            CSR_DELAY_FRAMES:  delay_frames_in  = csr_wr_data[DELAY_WIDTH-1:0];
            CSR_CHANNEL_COUNT: channel_count_in = csr_wr_data[CHCNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_level_ff     <= MIX_RESET;
         feedback_gain_ff <= FB_RESET;
         delay_frames_ff  <= DELAY_RESET;
         channel_count_ff <= CHCNT_RESET;
      end else begin
         mix_level_ff     <= mix_level_in;
         feedback_gain_ff <= feedback_gain_in;
         delay_frames_ff  <= delay_frames_in;
         channel_count_ff <= channel_count_in;
      end
   end

   // ---------------- pointer state ----------------
   logic [FW-1:0] wp_ff, wp_in;
   logic [CW-1:0] slot_ff, slot_in;

   // clearing sweep
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: memory read in flight; stage 2: products registered
   logic          v1_ff, v1_in, v2_ff, v2_in;
   logic          byp1_ff, byp2_ff;
   logic [AW-1:0] wr_addr1_ff, wr_addr2_ff;
   sample_type    dry1_ff;
   sample_type    rd_data_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   sample_type    rsp_sample_ff;

   logic          bypass_now;
   logic [XW-1:0] dly_x;
   logic [FW-1:0] rd_frame;
   logic [NW-1:0] ch_x, chans_x;
   logic [CW-1:0] ch;
   logic          frame_last;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          hazard;
   logic          accept, mv2, mv_out;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   sample_type    mem_wd;
   sample_type    store_sample, mix_sample;
   coef_type      coef;

   assign bypass_now = (mix_level_ff == '0);

   // delay clamped to [1, CAPACITY_FRAMES-1], channel count to [1, MAX_CHANNELS]
   always_comb begin
      dly_x = XW'(delay_frames_ff);
      if (dly_x == '0) begin
         dly_x = XW'(1);
      end else if (dly_x > XW'(CAPACITY_FRAMES - 1)) begin
         dly_x = XW'(CAPACITY_FRAMES - 1);
      end
      if (XW'(wp_ff) >= dly_x) begin
         rd_frame = FW'(XW'(wp_ff) - dly_x);
      end else begin
         rd_frame = FW'(XW'(wp_ff) + XW'(CAPACITY_FRAMES) - dly_x);
      end

      if (channel_count_ff == '0) begin
         chans_x = NW'(1);
      end else if (NW'(channel_count_ff) > NW'(MAX_CHANNELS)) begin
         chans_x = NW'(MAX_CHANNELS);
      end else begin
         chans_x = NW'(channel_count_ff);
      end
      ch_x = (NW'(slot_ff) >= NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS - 1) : NW'(slot_ff);
      ch   = ch_x[CW-1:0];
      // a lowered channel count mid-frame also ends the frame here
      frame_last = ((ch_x + NW'(1)) >= chans_x);

      rd_addr = AW'(rd_frame) * AW'(MAX_CHANNELS) + AW'(ch);
      wr_addr = AW'(wp_ff) * AW'(MAX_CHANNELS) + AW'(ch);
   end

   // read-after-write interlock: the entry about to be read is still owed
   // by a sample in stage 1 or 2
   assign hazard = !bypass_now &&
                   ((v1_ff && !byp1_ff && (wr_addr1_ff == rd_addr)) ||
                    (v2_ff && !byp2_ff && (wr_addr2_ff == rd_addr)));

   assign mv_out = v2_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign mv2    = v1_ff && (!v2_ff || mv_out);

   assign req_chan.ready = !clr_ff && (!v1_ff || mv2) && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;

   // pointers advance only on a wet transfer
   always_comb begin
      wp_in   = wp_ff;
      slot_in = slot_ff;
      if (accept && !bypass_now) begin
         if (frame_last) begin
            slot_in = '0;
            wp_in   = (wp_ff == FW'(CAPACITY_FRAMES - 1)) ? '0 : wp_ff + FW'(1);
         end else begin
            slot_in = CW'(ch_x + NW'(1));
         end
      end
   end

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_comb begin
      v1_in        = accept || (v1_ff && !mv2);
      v2_in        = mv2 || (v2_ff && !mv_out);
      rsp_valid_in = mv_out || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         slot_ff      <= '0;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         slot_ff      <= slot_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         byp1_ff     <= bypass_now;
         wr_addr1_ff <= wr_addr;
         dry1_ff     <= req_chan.sample_in;
      end
      if (mv2) begin
         byp2_ff     <= byp1_ff;
         wr_addr2_ff <= wr_addr1_ff;
      end
      if (mv_out) begin
         rsp_sample_ff <= mix_sample;
      end
   end

   // ---------------- echo memory ----------------
   sample_type echo_mem [DEPTH];

   always_comb begin
      mem_we = clr_ff || (mv_out && !byp2_ff);
      mem_wa = clr_ff ? clr_addr_ff : wr_addr2_ff;
      mem_wd = clr_ff ? sample_type'(0) : store_sample;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         echo_mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_data_ff <= echo_mem[rd_addr];
      end
   end

   // ---------------- arithmetic ----------------
   assign coef.mix_level     = mix_level_ff;
   assign coef.feedback_gain = feedback_gain_ff;

   fed_mix_math u_math (
      .clock        (clock),
      .load         (mv2),
      .dry          (dry1_ff),
      .wet          (rd_data_ff),
      .coef         (coef),
      .bypass       (byp2_ff),
      .store_sample (store_sample),
      .mix_sample   (mix_sample)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;

   // ---------------- checks ----------------
   `FED_ASSERT(a_no_xfer_in_clear, clock, reset, clr_ff |-> !accept && !v1_ff && !v2_ff, "sample taken during memory clear")
   `FED_ASSERT(a_bypass_holds_ptrs, clock, reset, (accept && bypass_now) |=> $stable(wp_ff) && $stable(slot_ff), "bypass moved pointers")
   `FED_ASSERT(a_wp_range, clock, reset, wp_ff <= FW'(CAPACITY_FRAMES - 1), "write pointer out of range")
   `FED_ASSERT(a_clear_full_sweep, clock, reset, $fell(clr_ff) |-> $past(clr_addr_ff) == AW'(DEPTH - 1), "clear ended early")
   `FED_ASSERT_ALWAYS(a_reset_starts_clear, clock, $past(reset) |-> clr_ff && (clr_addr_ff == '0), "reset did not restart clear")

endmodule
